// ===== src/lcf_pkg.sv =====
// ----------------------------------------------------------------------------
// lcf_pkg: shared definitions for the linear convolution FIR
// Widths, register indexes, the queue word type and the tap count clamp.
// ----------------------------------------------------------------------------
package lcf_pkg;

    localparam int TAPS        = 7;
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int PSUM_W      = PROD_W + 1;
    localparam int RESULT_W    = 35;
    localparam int TAP_CNT_W   = 3;
    localparam int TAPS_W      = $clog2(TAPS + 1);
    localparam int PAIRS       = (TAPS + 1) / 2;
    localparam int DLY_N       = (TAPS > 1) ? TAPS - 1 : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int REG_IDX_W   = 3;
    localparam int APB_ADDR_W  = REG_IDX_W + 2;
    localparam int APB_DATA_W  = 32;

    // Register indexes (byte address is four times the index).
    localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_0    = 3'd1;

    localparam logic [TAP_CNT_W-1:0]        TAP_COUNT_RESET = 3'd1;
    localparam logic signed [COEF_W-1:0]    COEF_0_RESET    = 16'sd32767;

    typedef logic signed [COEF_W-1:0] t_coef_arr [TAPS];

    typedef struct packed {
        logic                       frame_end;
        logic signed [SAMPLE_W-1:0] sample;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    // Number of taps actually used: zero counts as one, large values saturate.
    function automatic logic [TAPS_W-1:0] active_taps(input logic [TAP_CNT_W-1:0] tc);
        logic [TAPS_W-1:0] n;
        if (tc == '0) begin
            n = TAPS_W'(1);
        end else if (int'(tc) > TAPS) begin
            n = TAPS_W'(TAPS);
        end else begin
            n = TAPS_W'(tc);
        end
        return n;
    endfunction

endpackage

// ===== src/lcf_front.sv =====
// ----------------------------------------------------------------------------
// lcf_front: input queue of the linear convolution FIR
// Takes sample words from the input channel and holds them for the back end.
// ----------------------------------------------------------------------------
module lcf_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [lcf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_frame_end,
    output lcf_pkg::t_head                      o_head,
    input  logic                                i_pop
);
    import lcf_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;
    logic [QPTR_W:0]     n_count;
    logic                push;
    logic                pop;

    assign o_stall = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + (QPTR_W + 1)'(1);
        end else if (pop && !push) begin
            n_count = r_count - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{frame_end: i_frame_end, sample: i_sample};
        end
    end

endmodule

// ===== src/lcf_back.sv =====
// ----------------------------------------------------------------------------
// lcf_back: sequencer and multiply-accumulate pipeline
// Issues one tick per cycle unless the output stalls (a queued sample or a zero
// of the frame tail), keeps the delay line and sums the products over two pipeline stages.
// ----------------------------------------------------------------------------
module lcf_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lcf_pkg::t_head                       i_head,
    output logic                                 o_pop,
    input  lcf_pkg::t_coef_arr                   i_coef,
    input  logic [lcf_pkg::TAP_CNT_W-1:0]        i_tap_count,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [lcf_pkg::RESULT_W-1:0]  o_result,
    output logic                                 o_result_end
);
    import lcf_pkg::*;

    typedef enum logic [1:0] {
        ST_SAMPLE = 2'b01,
        ST_TAIL   = 2'b10
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    logic [TAPS_W-1:0]          r_tail_k;
    logic [TAPS_W-1:0]          n_tail_k;
    logic signed [SAMPLE_W-1:0] r_dly [DLY_N];

    logic                       r_s1_valid;
    logic                       r_s1_end;
    logic signed [PROD_W-1:0]   r_prod [TAPS];
    logic                       r_s2_valid;
    logic                       r_s2_end;
    logic signed [PSUM_W-1:0]   r_psum [PAIRS];
    logic                       r_out_valid;
    logic signed [RESULT_W-1:0] r_result;
    logic                       r_result_end;

    logic                       en;
    logic                       issue;
    logic                       is_end;
    logic                       clear;
    logic signed [SAMPLE_W-1:0] x;
    logic [TAPS_W-1:0]          n;
    logic signed [COEF_W-1:0]   coef_used [TAPS];
    logic signed [RESULT_W-1:0] acc;

    assign n  = active_taps(i_tap_count);
    assign en = !r_out_valid || !i_stall;

    always_comb begin
        issue    = 1'b0;
        is_end   = 1'b0;
        clear    = 1'b0;
        o_pop    = 1'b0;
        x        = '0;
        n_state  = r_state;
        n_tail_k = r_tail_k;
        if (en) begin
            case (r_state)
                ST_SAMPLE: begin
                    if (i_head.valid) begin
                        issue = 1'b1;
                        o_pop = 1'b1;
                        x     = i_head.item.sample;
                        if (i_head.item.frame_end) begin
                            if (n == TAPS_W'(1)) begin
                                is_end = 1'b1;
                                clear  = 1'b1;
                            end else begin
                                n_state  = ST_TAIL;
                                n_tail_k = TAPS_W'(1);
                            end
                        end
                    end
                end
                ST_TAIL: begin
                    issue = 1'b1;
                    if (r_tail_k == n - TAPS_W'(1)) begin
                        is_end  = 1'b1;
                        clear   = 1'b1;
                        n_state = ST_SAMPLE;
                    end else begin
                        n_tail_k = r_tail_k + TAPS_W'(1);
                    end
                end
                default: begin
                    n_state = ST_SAMPLE;
                end
            endcase
        end
    end

    // Taps at or above the active count contribute nothing.
    always_comb begin
        for (int j = 0; j < TAPS; j++) begin
            coef_used[j] = (TAPS_W'(j) < n) ? i_coef[j] : '0;
        end
    end

    always_comb begin
        acc = '0;
        for (int p = 0; p < PAIRS; p++) begin
            acc = acc + RESULT_W'(r_psum[p]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SAMPLE;
            r_tail_k    <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < DLY_N; j++) begin
                r_dly[j] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_tail_k <= n_tail_k;
            if (en) begin
                r_s1_valid  <= issue;
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= r_s2_valid;
            end
            if (issue) begin
                if (clear) begin
                    for (int j = 0; j < DLY_N; j++) begin
                        r_dly[j] <= '0;
                    end
                end else if (TAPS > 1) begin
                    for (int j = DLY_N - 1; j > 0; j--) begin
                        r_dly[j] <= r_dly[j - 1];
                    end
                    r_dly[0] <= x;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_end <= is_end;
            r_prod[0] <= coef_used[0] * x;
            for (int j = 1; j < TAPS; j++) begin
                r_prod[j] <= coef_used[j] * r_dly[j - 1];
            end
            r_s2_end <= r_s1_end;
            for (int p = 0; p < PAIRS; p++) begin
                if (2 * p + 1 < TAPS) begin
                    r_psum[p] <= PSUM_W'(r_prod[2 * p]) + PSUM_W'(r_prod[2 * p + 1]);
                end else begin
                    r_psum[p] <= PSUM_W'(r_prod[2 * p]);
                end
            end
            r_result     <= acc;
            r_result_end <= r_s2_end;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_result     = r_result;
    assign o_result_end = r_result_end;

endmodule

// ===== src/linear_convolution_fir.sv =====
// ----------------------------------------------------------------------------
// linear_convolution_fir: full linear convolution FIR, up to seven taps
// Convolves framed Q1.15 samples with Q1.15 coefficients into exact Q5.30.
// ----------------------------------------------------------------------------
// Samples arrive on the input channel (i_valid, o_stall, i_sample,
// i_frame_end); a word is taken at each rising edge with i_valid high and
// o_stall low. Results leave on the output channel (o_valid, i_stall,
// o_result, o_result_end) and are taken when o_valid is high and i_stall low.
// Every sample gives one result. A sample with i_frame_end set also gives
// tap_count minus one tail results, one per cycle unless the receiver stalls,
// after which the delay line is cleared; o_result_end marks the last result
// of the frame. Throughput is one result per cycle unless the receiver stalls,
// set by the single multiply-accumulate pipeline. A result passes through
// the queue, the product stage, the pair-sum stage and the output register.
// A four-word queue sits between the input and the sequencer, so input words
// keep being taken while a result waits; when the receiver stalls, the
// pipeline holds and o_stall rises only once the queue is full.
// Coefficients and tap_count must be written over the APB port only while idle; the block itself does not enforce this.
// Reset (synchronous, i_rst_n low) empties the queue and pipeline, clears
// the delay line and sets tap_count to one, coef_0 to 32767 and the rest to 0.
module linear_convolution_fir (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lcf_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [lcf_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [lcf_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [lcf_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                                  i_frame_end,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [lcf_pkg::RESULT_W-1:0]   o_result,
    output logic                                  o_result_end
);
    import lcf_pkg::*;

    logic [TAP_CNT_W-1:0]   r_tap_count;
    t_coef_arr              r_coef;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   wr_en;
    t_head                  head;
    logic                   pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes. Index zero is tap_count; the coefficients follow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RESET;
            r_coef[0]   <= COEF_0_RESET;
            for (int j = 1; j < TAPS; j++) begin
                r_coef[j] <= '0;
            end
        end else if (wr_en) begin
            if (reg_idx == REG_TAP_COUNT) begin
                r_tap_count <= pwdata[TAP_CNT_W-1:0];
            end
            for (int j = 0; j < TAPS; j++) begin
                if (int'(reg_idx) == int'(REG_COEF_0) + j) begin
                    r_coef[j] <= pwdata[COEF_W-1:0];
                end
            end
        end
    end

    // Read back: tap_count zero-extended, coefficients sign-extended.
    always_comb begin
        prdata = '0;
        if (reg_idx == REG_TAP_COUNT) begin
            prdata = APB_DATA_W'(r_tap_count);
        end
        for (int j = 0; j < TAPS; j++) begin
            if (int'(reg_idx) == int'(REG_COEF_0) + j) begin
                prdata = APB_DATA_W'(r_coef[j]);
            end
        end
    end

    lcf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .i_frame_end (i_frame_end),
        .o_head      (head),
        .i_pop       (pop)
    );

    lcf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .i_coef       (r_coef),
        .i_tap_count  (r_tap_count),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result     (o_result),
        .o_result_end (o_result_end)
    );

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the linear convolution FIR
// Programs tap counts and coefficients over APB, streams framed samples with
// bursty valid and a stalling receiver, and checks every result word against
// a bit-exact convolution predictor running alongside the block.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lcf_pkg::*;

    // One expected result word: the exact Q5.30 sum and the end-of-frame flag.
    typedef struct packed {
        logic signed [RESULT_W-1:0] value;
        logic                       last;
    } t_expect;

    // One row of the directed table. When typed is set, the result columns
    // hold the expected first result, otherwise the predictor supplies it.
    typedef struct packed {
        logic [2:0]                 setting;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_end;
        logic                       typed;
        logic signed [RESULT_W-1:0] result;
        logic                       result_end;
    } t_row;

    localparam int N_DIRECTED  = 24;
    localparam int N_PHASES    = 6;
    localparam int PHASE_WORDS = 16;
    localparam int HOLD_CYCLES = 80;

    // Setting 0 is the reset state, so those rows have typed results. Setting 1
    // and 2 drive every coefficient to an extreme with all seven taps, which
    // exercises the largest sums. Setting 3 writes a tap count of zero, which
    // acts as one tap, with nonzero coefficients above it that must be
    // ignored. Setting 4 uses three taps and includes a frame of one sample.
    // Setting 5 only raises the tap count, so the coefficients left over from
    // setting 4 must still be in place.
    t_row directed_rows [N_DIRECTED] = '{
        '{3'd0, 16'sd0,     1'b0, 1'b1,  35'sd0,          1'b0},
        '{3'd0, 16'sd32767, 1'b0, 1'b1,  35'sd1073676289, 1'b0},
        '{3'd0, 16'h8000,   1'b0, 1'b1, -35'sd1073709056, 1'b0},
        '{3'd0, 16'sd1,     1'b1, 1'b1,  35'sd32767,      1'b1},
        '{3'd0, -16'sd1,    1'b1, 1'b1, -35'sd32767,      1'b1},
        '{3'd1, 16'h8000,   1'b0, 1'b0,  35'sd0,          1'b0},
        '{3'd1, 16'h8000,   1'b0, 1'b0,  35'sd0,          1'b0},
        '{3'd1, 16'h8000,   1'b0, 1'b0,  35'sd0,          1'b0},
        '{3'd1, 16'h8000,   1'b0, 1'b0,  35'sd0,          1'b0},
        '{3'd1, 16'h8000,   1'b0, 1'b0,  35'sd0,          1'b0},
        '{3'd1, 16'h8000,   1'b0, 1'b0,  35'sd0,          1'b0},
        '{3'd1, 16'h8000,   1'b0, 1'b0,  35'sd0,          1'b0},
        '{3'd1, 16'h8000,   1'b1, 1'b0,  35'sd0,          1'b0},
        '{3'd2, 16'h8000,   1'b0, 1'b0,  35'sd0,          1'b0},
        '{3'd2, 16'h8000,   1'b0, 1'b0,  35'sd0,          1'b0},
        '{3'd2, 16'h8000,   1'b0, 1'b0,  35'sd0,          1'b0},
        '{3'd2, 16'sd32767, 1'b1, 1'b0,  35'sd0,          1'b0},
        '{3'd3, 16'sd32767, 1'b0, 1'b1, -35'sd1073709056, 1'b0},
        '{3'd3, 16'h8000,   1'b1, 1'b1,  35'sd1073741824, 1'b1},
        '{3'd4, 16'sd1000,  1'b1, 1'b0,  35'sd0,          1'b0},
        '{3'd4, 16'sd5,     1'b0, 1'b0,  35'sd0,          1'b0},
        '{3'd4, -16'sd7,    1'b1, 1'b0,  35'sd0,          1'b0},
        '{3'd5, 16'sd100,   1'b0, 1'b0,  35'sd0,          1'b0},
        '{3'd5, 16'sd200,   1'b1, 1'b0,  35'sd0,          1'b0}
    };

    // Block ports. Every input starts at a known value.
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0]         paddr       = '0;
    logic [APB_DATA_W-1:0]         pwdata      = '0;
    logic [APB_DATA_W-1:0]         prdata;
    logic                          pready;
    logic                          i_valid     = 1'b0;
    logic                          o_stall;
    logic signed [SAMPLE_W-1:0]    i_sample    = '0;
    logic                          i_frame_end = 1'b0;
    logic                          o_valid;
    logic                          i_stall     = 1'b0;
    logic signed [RESULT_W-1:0]    o_result;
    logic                          o_result_end;

    // Predictor state: its own copy of the registers and the delay line.
    logic [TAP_CNT_W-1:0]          model_taps;
    logic signed [COEF_W-1:0]      model_coef [TAPS];
    logic signed [SAMPLE_W-1:0]    model_line [DLY_N];

    t_expect expected_results [$];
    int      errors      = 0;
    int      burst_left  = 0;
    bit      no_gaps     = 1'b0;
    int      hold_req    = 0;

    linear_convolution_fir dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .i_frame_end  (i_frame_end),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result     (o_result),
        .o_result_end (o_result_end)
    );

    // 8 ns clock period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The run is cut off well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Put the predictor into its reset state.
    task automatic reset_model();
        int j;
        model_taps = TAP_COUNT_RESET;
        for (j = 0; j < TAPS; j++) begin
            model_coef[j] = '0;
        end
        model_coef[0] = COEF_0_RESET;
        for (j = 0; j < DLY_N; j++) begin
            model_line[j] = '0;
        end
    endtask

    // Compute the result words that one accepted sample causes and queue them.
    // A frame end adds tail words with zeros shifted in, then clears the line.
    // For a typed directed row the first word comes from the table instead.
    task automatic convolve_word(input logic signed [SAMPLE_W-1:0] x, input logic fe,
                                 input logic typed, input t_expect typed_word);
        int      n;
        int      count;
        int      k;
        int      j;
        longint  acc;
        logic signed [SAMPLE_W-1:0] s;
        t_expect w;
        // A tap count of zero still uses one tap; larger counts saturate.
        if (model_taps == '0) begin
            n = 1;
        end else if (int'(model_taps) > TAPS) begin
            n = TAPS;
        end else begin
            n = int'(model_taps);
        end
        count = fe ? n : 1;
        for (k = 0; k < count; k++) begin
            s = (k == 0) ? x : '0;
            acc = longint'(model_coef[0]) * longint'(s);
            for (j = 1; j < n; j++) begin
                acc += longint'(model_coef[j]) * longint'(model_line[j-1]);
            end
            for (j = DLY_N - 1; j > 0; j--) begin
                model_line[j] = model_line[j-1];
            end
            model_line[0] = s;
            w.value = acc[RESULT_W-1:0];
            w.last  = fe && (k == count - 1);
            if (typed && k == 0) begin
                w = typed_word;
            end
            expected_results.push_back(w);
        end
        if (fe) begin
            for (j = 0; j < DLY_N; j++) begin
                model_line[j] = '0;
            end
        end
    endtask

    // One APB write: a setup phase, then an access phase that completes on
    // pready. The predictor takes the same value once the write has landed.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_TAP_COUNT) begin
            model_taps = value[TAP_CNT_W-1:0];
        end else begin
            model_coef[int'(idx - REG_COEF_0)] = value[COEF_W-1:0];
        end
    endtask

    // Write the tap count and, unless only the count changes, all coefficients.
    task automatic program_filter(input logic [TAP_CNT_W-1:0] taps,
                                  input logic signed [COEF_W-1:0] c [TAPS],
                                  input bit taps_only);
        int j;
        write_reg(REG_TAP_COUNT, APB_DATA_W'(taps));
        if (!taps_only) begin
            for (j = 0; j < TAPS; j++) begin
                write_reg(REG_IDX_W'(int'(REG_COEF_0) + j),
                          {{(APB_DATA_W-COEF_W){c[j][COEF_W-1]}}, c[j]});
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // The fixed settings used by the directed table.
    task automatic apply_setting(input int k);
        logic signed [COEF_W-1:0] c [TAPS];
        logic [TAP_CNT_W-1:0]     taps;
        bit                       taps_only;
        int                       j;
        taps_only = 1'b0;
        taps      = 3'd7;
        for (j = 0; j < TAPS; j++) begin
            c[j] = -16'sd1;
        end
        case (k)
            1: begin
                for (j = 0; j < TAPS; j++) c[j] = 16'h8000;
            end
            2: begin
                for (j = 0; j < TAPS; j++) c[j] = 16'sd32767;
            end
            3: begin
                taps = 3'd0;
                c[0] = 16'h8000;
                for (j = 1; j < TAPS; j++) c[j] = 16'sd12345;
            end
            4: begin
                taps = 3'd3;
                c[0] = 16'sd16384;
                c[1] = -16'sd16384;
                c[2] = 16'sd32767;
            end
            default: begin
                taps_only = 1'b1;
            end
        endcase
        program_filter(taps, c, taps_only);
    endtask

    // Coefficient values lean on the two extremes.
    function automatic logic signed [COEF_W-1:0] pick_value();
        logic signed [COEF_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'sd32767;
            1:       v = 16'h8000;
            2:       v = '0;
            default: v = COEF_W'($urandom);
        endcase
        return v;
    endfunction

    // A random setting for one phase of the random part. The first phase uses
    // the full seven taps, the second a tap count of zero, and the last only
    // rewrites the tap count.
    task automatic randomize_setting(input int phase);
        logic signed [COEF_W-1:0] c [TAPS];
        logic [TAP_CNT_W-1:0]     taps;
        int                       j;
        for (j = 0; j < TAPS; j++) begin
            c[j] = pick_value();
        end
        if (phase == 0) begin
            taps = 3'd7;
        end else if (phase == 1) begin
            taps = 3'd0;
        end else begin
            taps = TAP_CNT_W'($urandom_range(0, 7));
        end
        program_filter(taps, c, phase == N_PHASES - 1);
    endtask

    // Sender pacing: bursts of random length separated by random gaps. With
    // no_gaps set the sender offers a word on every cycle.
    task automatic pace();
        int gap;
        if (!no_gaps) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 12);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
        end
    endtask

    // Offer one sample word and hold it until the block takes it, then let
    // the predictor account for it.
    task automatic send_word(input logic signed [SAMPLE_W-1:0] x, input logic fe,
                             input logic typed, input t_expect typed_word);
        i_valid     <= 1'b1;
        i_sample    <= x;
        i_frame_end <= fe;
        do @(posedge i_clk); while (o_stall);
        convolve_word(x, fe, typed, typed_word);
    endtask

    // The sender stops and waits until every expected word has come out, so
    // that the block is idle before a register write.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Receiver: stalls on a pattern of its own, picking a new stall density
    // whenever pat_cnt runs out so that stall-free stretches occur too. A hold request
    // from the stimulus starts a long stretch of stall counted here.
    int hold_served = 0;
    int hold_left   = 0;
    int pat_cnt     = 0;
    int stall_pct   = 0;
    always @(posedge i_clk) begin
        if (hold_served != hold_req) begin
            hold_served = hold_req;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (pat_cnt == 0) begin
                pat_cnt = 32;
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 20;
                    3:       stall_pct = 50;
                    default: stall_pct = 80;
                endcase
            end
            pat_cnt--;
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Result checker: every accepted word must match the oldest expectation.
    t_expect want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: result=%0d result_end=%0b",
                       o_result, o_result_end);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_result !== want.value) begin
                    $error("result: expected %0d, actual %0d", want.value, o_result);
                    errors++;
                end
                if (o_result_end !== want.last) begin
                    $error("result_end: expected %0b, actual %0b", want.last, o_result_end);
                    errors++;
                end
            end
        end
    end

    // Random sample values, with the extremes and zero well represented.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 15))
            0, 1:    v = 16'sd32767;
            2, 3:    v = 16'h8000;
            4:       v = '0;
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    // Main stimulus.
    initial begin : stimulus
        int      r;
        int      cur;
        int      ph;
        int      i;
        int      frame_left;
        int      waited;
        logic    fe;
        t_row    row;
        reset_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: switch settings only with the block idle.
        cur = 0;
        for (r = 0; r < N_DIRECTED; r++) begin
            row = directed_rows[r];
            if (int'(row.setting) != cur) begin
                drain_results();
                apply_setting(int'(row.setting));
                cur = int'(row.setting);
            end
            pace();
            send_word(row.sample, row.frame_end, row.typed, '{row.result, row.result_end});
        end

        // Random part: frames of random length under a fresh setting per
        // phase. Phase 2 offers words back to back while the receiver holds
        // off, so the input queue fills and o_stall rises. Phase 4 may end in
        // the middle of a frame, so the delay line carries across a write.
        frame_left = 0;
        for (ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            randomize_setting(ph);
            no_gaps = (ph == 2);
            if (ph == 2) begin
                hold_req++;
            end
            for (i = 0; i < PHASE_WORDS; i++) begin
                if (frame_left == 0) begin
                    frame_left = $urandom_range(1, 8);
                end
                frame_left--;
                fe = (frame_left == 0);
                if (i == PHASE_WORDS - 1 && ph != 4) begin
                    fe = 1'b1;
                    frame_left = 0;
                end
                pace();
                send_word(pick_sample(), fe, 1'b0, '0);
            end
        end
        no_gaps = 1'b0;

        // Wait for the tail of the last frame, with a limit, then let the clock
        // run on to catch any stray word.
        i_valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < 50000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (16) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected result words never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
